@@ rtl/core/lspe_pkg.sv @@
// ----------------------------------------------------------------------------
// LED strip pulse encoder package
// Shared item types, configuration layout, codes and the colour palette.
// ----------------------------------------------------------------------------
`default_nettype none

package lspe_pkg;

  localparam int BITS_PER_LED = 24;
  localparam int BIT_CNT_W    = 5;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(BITS_PER_LED - 1);

  localparam int MAX_LEDS = 256;
  localparam int LEN_W    = 9;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEDS);

  // restoring divider: quotient fits 8 bits, one bit per step
  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  // item queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;
  localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

  // configuration register indexes
  localparam logic [2:0] CFG_COLOR_CODE  = 3'd0;
  localparam logic [2:0] CFG_STRIP_LEN   = 3'd1;
  localparam logic [2:0] CFG_PULSE_ONE   = 3'd2;
  localparam logic [2:0] CFG_PULSE_ZERO  = 3'd3;
  localparam logic [2:0] CFG_BRIGHT_LVLS = 3'd4;

  // pattern codes
  localparam logic [2:0] PAT_DARK   = 3'd0;
  localparam logic [2:0] PAT_ALL    = 3'd1;
  localparam logic [2:0] PAT_BELOW  = 3'd2;
  localparam logic [2:0] PAT_FROM   = 3'd3;
  localparam logic [2:0] PAT_SINGLE = 3'd4;

  // palette codes
  localparam logic [2:0] COLOR_BLACK  = 3'd0;
  localparam logic [2:0] COLOR_RED    = 3'd1;
  localparam logic [2:0] COLOR_GREEN  = 3'd2;
  localparam logic [2:0] COLOR_BLUE   = 3'd3;
  localparam logic [2:0] COLOR_WHITE  = 3'd4;
  localparam logic [2:0] COLOR_ORANGE = 3'd5;
  localparam logic [2:0] COLOR_YELLOW = 3'd6;

  typedef struct packed {
    logic [7:0] led_index;
    logic [8:0] frame_position;
    logic [7:0] brightness_level;
    logic [2:0] pattern;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pulse_width;
    logic        last_of_led;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  color_code;
    logic [8:0]  strip_length;
    logic [15:0] pulse_one;
    logic [15:0] pulse_zero;
    logic [7:0]  brightness_levels;
  } cfg_t;

  // front -> queue
  typedef struct packed {
    logic                    valid;
    logic [BITS_PER_LED-1:0] word;
  } q_wr_t;

  // queue -> back
  typedef struct packed {
    logic                    valid;
    logic [BITS_PER_LED-1:0] word;
  } q_rd_t;

  // returns {r, g, b}
  function automatic logic [23:0] palette_rgb(input logic [2:0] code);
    logic [23:0] rgb;
    unique case (code)
      COLOR_RED:    rgb = {8'd255, 8'd0,   8'd0};
      COLOR_GREEN:  rgb = {8'd0,   8'd255, 8'd0};
      COLOR_BLUE:   rgb = {8'd0,   8'd0,   8'd255};
      COLOR_WHITE:  rgb = {8'd255, 8'd255, 8'd255};
      COLOR_ORANGE: rgb = {8'd255, 8'd153, 8'd102};
      COLOR_YELLOW: rgb = {8'd255, 8'd127, 8'd0};
      default:      rgb = 24'd0;
    endcase
    return rgb;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lspe_front.sv @@
// ----------------------------------------------------------------------------
// LED strip pulse encoder front
// Classifies a slot as lit or dark, scales the palette colour by level over
// levels with three lanes of a bit-serial divider, and queues the GRB word.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lspe_pkg::in_item_t item,
  input  lspe_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              busy,
  output lspe_pkg::q_wr_t   q_wr
);
  import lspe_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_DIV, F_PUSH} front_state_t;

  front_state_t         state;
  logic [DIV_CNT_W-1:0] step;
  logic                 black;
  logic [2:0][7:0]      chan;    // lanes: 2 green, 1 red, 0 blue
  logic [7:0]           level;
  logic [2:0][7:0]      rem;
  logic [2:0][7:0]      low;     // dividend low bits, quotient shifts in

  logic [LEN_W-1:0]  len_eff;
  logic              lit;
  logic [7:0]        level_next;
  logic [23:0]       rgb;
  logic [2:0][15:0]  prod;
  logic [2:0][7:0]   rem_next;
  logic [2:0][7:0]   low_next;

  always_comb begin
    len_eff = (cfg.strip_length > MAX_LEN) ? MAX_LEN : cfg.strip_length;
    unique case (item.pattern)
      PAT_ALL:    lit = 1'b1;
      PAT_BELOW:  lit = {1'b0, item.led_index} <  item.frame_position;
      PAT_FROM:   lit = {1'b0, item.led_index} >= item.frame_position;
      PAT_SINGLE: lit = {1'b0, item.led_index} == item.frame_position;
      default:    lit = 1'b0;
    endcase
    if ({1'b0, item.led_index} >= len_eff) begin
      lit = 1'b0;
    end
    level_next = (item.brightness_level > cfg.brightness_levels) ?
                 cfg.brightness_levels : item.brightness_level;
    rgb = palette_rgb(cfg.color_code);
  end

  // one restoring step per lane; remainder stays below the divisor
  always_comb begin
    logic [8:0] t;
    logic       ge;
    for (int i = 0; i < 3; i++) begin
      prod[i] = 16'(chan[i]) * 16'(level);
      t  = {rem[i], low[i][7]};
      ge = t >= {1'b0, cfg.brightness_levels};
      rem_next[i] = ge ? 8'(t - {1'b0, cfg.brightness_levels}) : t[7:0];
      low_next[i] = {low[i][6:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) begin
            black <= !lit || (cfg.brightness_levels == 8'd0);
            chan  <= {rgb[15:8], rgb[23:16], rgb[7:0]};
            level <= level_next;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= prod[i][15:8];
            low[i] <= prod[i][7:0];
          end
          step  <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          rem  <= rem_next;
          low  <= low_next;
          step <= step + 1'b1;
          if (step == DIV_LAST) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign busy       = (state != F_IDLE);
  assign q_wr.valid = (state == F_PUSH) && !q_full;
  assign q_wr.word  = black ? '0 : {low[2], low[1], low[0]};

endmodule

`default_nettype wire

@@ rtl/core/lspe_fifo.sv @@
// ----------------------------------------------------------------------------
// LED strip pulse encoder queue
// Two-entry queue of GRB words between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_fifo (
  input  logic            clk,
  input  logic            rst,
  input  lspe_pkg::q_wr_t q_wr,
  input  logic            pop,
  output logic            full,
  output lspe_pkg::q_rd_t q_rd
);
  import lspe_pkg::*;

  logic [Q_DEPTH-1:0][BITS_PER_LED-1:0] mem;
  logic [Q_PTR_W-1:0] wptr;
  logic [Q_PTR_W-1:0] rptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_pop;

  assign do_pop = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (q_wr.valid) begin
        mem[wptr] <= q_wr.word;
        wptr      <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + Q_CNT_W'(q_wr.valid) - Q_CNT_W'(do_pop);
    end
  end

  assign full       = (count == Q_FULL_CNT);
  assign q_rd.valid = (count != '0);
  assign q_rd.word  = mem[rptr];

endmodule

`default_nettype wire

@@ rtl/core/lspe_back.sv @@
// ----------------------------------------------------------------------------
// LED strip pulse encoder back
// Shifts out one GRB word as 24 timer compare values, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_back (
  input  logic                clk,
  input  logic                rst,
  input  lspe_pkg::cfg_t      cfg,
  input  lspe_pkg::q_rd_t     q_rd,
  output logic                pop,
  output logic                strobe,
  output lspe_pkg::out_item_t result
);
  import lspe_pkg::*;

  logic                    active;
  logic [BIT_CNT_W-1:0]    cnt;
  logic [BITS_PER_LED-1:0] word;
  logic                    at_last;

  assign at_last = (cnt == LAST_BIT);
  assign pop     = q_rd.valid && (!active || at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (active) begin
        result.pulse_width <= word[BITS_PER_LED-1] ? cfg.pulse_one : cfg.pulse_zero;
        result.last_of_led <= at_last;
      end
      // load the next word so the next slot follows without a gap
      if (pop) begin
        word   <= q_rd.word;
        cnt    <= '0;
        active <= 1'b1;
      end else if (active) begin
        word <= word << 1;
        cnt  <= cnt + 1'b1;
        if (at_last) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/led_strip_pattern_pulse_encoder_core.sv @@
// ----------------------------------------------------------------------------
// LED strip pattern pulse encoder core
// Turns one LED slot into 24 timer compare values, GRB order, MSB first.
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------
//   item in   start && !busy         item   (in_item_t)
//   result    strobe, one cycle      result (out_item_t), cannot be held off
//   config    cfg_valid && cfg_ready cfg_index, cfg_data (ready always high)
//
// An item leaves the output as 24 compare values, one per cycle; the back
// end's bit shifter sets that rate. The front end works a slot in steps
// (capture, multiply, 8 divider steps, queue write) and runs ahead of it.
// The first result passes the front end steps, the queue and the back end.
// Reset: synchronous, clears control state and loads the register defaults.
// Stalls: busy rises while the front end works or waits on a full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module led_strip_pattern_pulse_encoder_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  lspe_pkg::in_item_t  item,
  output logic                strobe,
  output lspe_pkg::out_item_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import lspe_pkg::*;

  cfg_t  cfg;
  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  // User writes registers only while idle, so no shadow copy; not enforced.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_code        <= COLOR_BLACK;
      cfg.strip_length      <= 9'd10;
      cfg.pulse_one         <= 16'd61;
      cfg.pulse_zero        <= 16'd28;
      cfg.brightness_levels <= 8'd50;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COLOR_CODE:  cfg.color_code        <= cfg_data[2:0];
        CFG_STRIP_LEN:   cfg.strip_length      <= cfg_data[8:0];
        CFG_PULSE_ONE:   cfg.pulse_one         <= cfg_data;
        CFG_PULSE_ZERO:  cfg.pulse_zero        <= cfg_data;
        CFG_BRIGHT_LVLS: cfg.brightness_levels <= cfg_data[7:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Front: decide lit/dark, scale the colour, hand the word to the queue.
  lspe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .cfg    (cfg),
    .q_full (q_full),
    .busy   (busy),
    .q_wr   (q_wr)
  );

  // Queue: hold up to two finished words so both sides stall on their own.
  lspe_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .q_wr (q_wr),
    .pop  (q_pop),
    .full (q_full),
    .q_rd (q_rd)
  );

  // Back: shift the word out as compare values, back to back across slots.
  lspe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

@@ rtl/core/lspe_checker.sv @@
// ----------------------------------------------------------------------------
// LED strip pulse encoder checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module lspe_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                strobe,
  input lspe_pkg::out_item_t result
);

  // a slot's last value ends a run of strobes, never starts one
  a_last_in_run: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_of_led |->
      $past(strobe) && !$past(result.last_of_led))
    else $error("last_of_led without a preceding run of values");

  // the stream only breaks after a complete slot
  a_no_cut: assert property (@(posedge clk) disable iff (rst)
    $fell(strobe) |-> $past(result.last_of_led))
    else $error("result stream broken inside a slot");

  // an accepted item occupies the front end next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  // reset leaves no result pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe && !busy)
    else $error("activity right after reset");

endmodule

bind led_strip_pattern_pulse_encoder_core lspe_checker u_lspe_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

`default_nettype wire

@@ verif/led_strip_pattern_pulse_encoder_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED strip pattern pulse encoder core testbench
// Sends LED slots through the start/busy port, decodes each slot into the
// 24 expected compare values on the side, and checks every strobed pulse in
// order. Register settings change between phases once all pulses are out.
// ----------------------------------------------------------------------------

module led_strip_pattern_pulse_encoder_core_tb;
  import lspe_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int TAIL_CYCLES     = 40;
  localparam int RAND_PHASES     = 6;
  localparam int SLOTS_PER_PHASE = 21;

  // codes the block must tolerate but gives no meaning to
  localparam logic [2:0] CFG_SPARE   = 3'd7;
  localparam logic [2:0] COLOR_SPARE = 3'd7;
  localparam logic [2:0] PAT_SPARE_A = 3'd5;
  localparam logic [2:0] PAT_SPARE_B = 3'd6;
  localparam logic [2:0] PAT_SPARE_C = 3'd7;

  // Mirror of the register file plus the list of compare values still owed.
  class pulse_tracker;
    logic [2:0]  color_code;
    logic [8:0]  strip_length;
    logic [15:0] pulse_one;
    logic [15:0] pulse_zero;
    logic [7:0]  levels;
    out_item_t   owed_pulses[$];
    int          errors;

    function new();
      color_code   = COLOR_BLACK;
      strip_length = 9'd10;
      pulse_one    = 16'd61;
      pulse_zero   = 16'd28;
      levels       = 8'd50;
      errors       = 0;
    endfunction

    function int pending();
      return owed_pulses.size();
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_COLOR_CODE:  color_code   = data[2:0];
        CFG_STRIP_LEN:   strip_length = data[8:0];
        CFG_PULSE_ONE:   pulse_one    = data;
        CFG_PULSE_ZERO:  pulse_zero   = data;
        CFG_BRIGHT_LVLS: levels       = data[7:0];
        default: ;
      endcase
    endfunction

    // {r, g, b} of the selected palette entry
    function logic [23:0] base_color();
      case (color_code)
        COLOR_RED:    return {8'd255, 8'd0,   8'd0};
        COLOR_GREEN:  return {8'd0,   8'd255, 8'd0};
        COLOR_BLUE:   return {8'd0,   8'd0,   8'd255};
        COLOR_WHITE:  return {8'd255, 8'd255, 8'd255};
        COLOR_ORANGE: return {8'd255, 8'd153, 8'd102};
        COLOR_YELLOW: return {8'd255, 8'd127, 8'd0};
        default:      return 24'd0;
      endcase
    endfunction

    function logic [7:0] dim(logic [7:0] chan, logic [7:0] lvl);
      int num;
      if (levels == 8'd0) return 8'd0;
      num = (lvl > levels) ? int'(levels) : int'(lvl);
      return 8'((int'(chan) * num) / int'(levels));
    endfunction

    function bit is_lit(in_item_t s);
      int len;
      int idx;
      int pos;
      len = (int'(strip_length) > MAX_LEDS) ? MAX_LEDS : int'(strip_length);
      idx = int'(s.led_index);
      pos = int'(s.frame_position);
      if (idx >= len) return 1'b0;
      case (s.pattern)
        PAT_ALL:    return 1'b1;
        PAT_BELOW:  return idx < pos;
        PAT_FROM:   return idx >= pos;
        PAT_SINGLE: return idx == pos;
        default:    return 1'b0;
      endcase
    endfunction

    // Queue the 24 compare values of one slot: green, red, blue, MSB first.
    function void note_slot(in_item_t s);
      logic [23:0] rgb;
      logic [23:0] grb;
      out_item_t   p;
      rgb = is_lit(s) ? base_color() : 24'd0;
      grb = {dim(rgb[15:8], s.brightness_level), dim(rgb[23:16], s.brightness_level),
             dim(rgb[7:0], s.brightness_level)};
      for (int k = 0; k < BITS_PER_LED; k++) begin
        p.pulse_width = grb[BITS_PER_LED-1-k] ? pulse_one : pulse_zero;
        p.last_of_led = (k == BITS_PER_LED - 1);
        owed_pulses.push_back(p);
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_pulse(out_item_t got);
      out_item_t want;
      if (owed_pulses.size() == 0) begin
        report($sformatf("pulse %0d last %0b with none owed", got.pulse_width,
                         got.last_of_led));
        return;
      end
      want = owed_pulses.pop_front();
      if (got.pulse_width !== want.pulse_width)
        report($sformatf("pulse_width %0d, want %0d", got.pulse_width, want.pulse_width));
      if (got.last_of_led !== want.last_of_led)
        report($sformatf("last_of_led %0b, want %0b", got.last_of_led, want.last_of_led));
    endtask
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic        busy;
  in_item_t    item      = '0;
  logic        strobe;
  out_item_t   result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  pulse_tracker sb;
  int burst_left = 0;

  led_strip_pattern_pulse_encoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample every handshake at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_slot(item);
      if (strobe) sb.check_pulse(result);
    end
  end

  // End the run when nothing has moved on any port for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Present one slot and hold it until accepted. Open a new burst when the
  // last one is used up, with a random gap first (sometimes none).
  task automatic send_slot(input in_item_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    item  <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every owed pulse has come out.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic end_cfg();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [2:0] color, input logic [8:0] len,
                           input logic [15:0] one, input logic [15:0] zero,
                           input logic [7:0] lv);
    write_reg(CFG_COLOR_CODE, {13'd0, color});
    write_reg(CFG_STRIP_LEN, {7'd0, len});
    write_reg(CFG_PULSE_ONE, one);
    write_reg(CFG_PULSE_ZERO, zero);
    write_reg(CFG_BRIGHT_LVLS, {8'd0, lv});
    end_cfg();
  endtask

  // Pick a fresh register set: mostly ordinary, sometimes an edge value.
  // Upper data bits carry junk the block must ignore.
  task automatic random_setup();
    logic [8:0] len;
    logic [7:0] lv;
    case ($urandom_range(0, 9))
      0:       len = 9'd0;
      1:       len = 9'd1;
      2:       len = 9'd256;
      3:       len = 9'($urandom_range(257, 511));
      default: len = 9'($urandom_range(2, 256));
    endcase
    case ($urandom_range(0, 9))
      0:       lv = 8'd0;
      1:       lv = 8'd1;
      2:       lv = 8'd255;
      default: lv = 8'($urandom_range(2, 254));
    endcase
    write_reg(CFG_COLOR_CODE, {13'($urandom), 3'($urandom_range(0, 7))});
    write_reg(CFG_STRIP_LEN, {7'($urandom), len});
    write_reg(CFG_PULSE_ONE, 16'($urandom));
    write_reg(CFG_PULSE_ZERO, 16'($urandom));
    write_reg(CFG_BRIGHT_LVLS, {8'($urandom), lv});
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom));
    end_cfg();
  endtask

  function automatic in_item_t slot(input int idx, input int pos, input int lvl,
                                    input logic [2:0] pat);
    in_item_t s;
    s.led_index        = 8'(idx);
    s.frame_position   = 9'(pos);
    s.brightness_level = 8'(lvl);
    s.pattern          = pat;
    return s;
  endfunction

  // Keep most slots inside the strip and positions near the slot so the
  // pattern boundaries get hit; leave some fully random.
  function automatic in_item_t rand_slot();
    in_item_t s;
    int       span;
    int       roll;
    span = (int'(sb.strip_length) > MAX_LEDS) ? MAX_LEDS : int'(sb.strip_length);
    if (span == 0 || $urandom_range(0, 4) == 0) s.led_index = 8'($urandom);
    else s.led_index = 8'($urandom_range(0, (span >= 255) ? 255 : span));
    roll = $urandom_range(0, 9);
    if (roll < 2)      s.pattern = PAT_ALL;
    else if (roll < 4) s.pattern = PAT_BELOW;
    else if (roll < 6) s.pattern = PAT_FROM;
    else if (roll < 8) s.pattern = PAT_SINGLE;
    else               s.pattern = 3'($urandom);
    if ($urandom_range(0, 2) == 0) s.frame_position = 9'($urandom);
    else s.frame_position = 9'(int'(s.led_index) + int'($urandom_range(0, 2)) - 1);
    if ($urandom_range(0, 4) == 0) s.brightness_level = 8'($urandom);
    else s.brightness_level = 8'($urandom_range(0, int'(sb.levels)));
    return s;
  endfunction

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Reset settings: black palette, ten LEDs; the boundary slot stays dark.
    send_slot(slot(0, 0, 50, PAT_ALL));
    send_slot(slot(9, 0, 255, PAT_ALL));
    send_slot(slot(10, 0, 50, PAT_ALL));
    drain();

    // Full white, widest strip, extreme compare values.
    load_regs(COLOR_WHITE, 9'd256, 16'hFFFF, 16'h0000, 8'd255);
    send_slot(slot(255, 0, 255, PAT_ALL));
    send_slot(slot(0, 0, 255, PAT_DARK));
    send_slot(slot(255, 256, 255, PAT_BELOW));
    send_slot(slot(0, 0, 255, PAT_BELOW));
    send_slot(slot(255, 511, 255, PAT_FROM));
    send_slot(slot(0, 0, 128, PAT_FROM));
    send_slot(slot(128, 128, 255, PAT_SINGLE));
    send_slot(slot(128, 384, 255, PAT_SINGLE));
    send_slot(slot(0, 0, 255, PAT_SPARE_A));
    send_slot(slot(1, 0, 255, PAT_SPARE_B));
    send_slot(slot(2, 0, 255, PAT_SPARE_C));
    send_slot(slot(3, 0, 0, PAT_ALL));
    drain();

    // Over-long strip with zero levels: everything black.
    load_regs(COLOR_ORANGE, 9'd300, 16'd61, 16'd28, 8'd0);
    send_slot(slot(255, 0, 200, PAT_ALL));
    drain();

    // One level: any nonzero level saturates to full colour.
    load_regs(COLOR_ORANGE, 9'd300, 16'd61, 16'd28, 8'd1);
    send_slot(slot(255, 0, 255, PAT_ALL));
    send_slot(slot(5, 0, 0, PAT_ALL));
    drain();

    // Unused palette code gives black.
    load_regs(COLOR_SPARE, 9'd10, 16'd61, 16'd28, 8'd3);
    send_slot(slot(0, 0, 2, PAT_ALL));
    drain();

    // Empty strip, then a single LED.
    load_regs(COLOR_YELLOW, 9'd0, 16'd61, 16'd28, 8'd3);
    send_slot(slot(0, 0, 3, PAT_ALL));
    drain();
    load_regs(COLOR_YELLOW, 9'd1, 16'd61, 16'd28, 8'd3);
    send_slot(slot(0, 0, 2, PAT_ALL));
    send_slot(slot(1, 1, 3, PAT_FROM));
    drain();

    // Remaining primaries with uneven scaling; poke the unused register index.
    load_regs(COLOR_GREEN, 9'd256, 16'd1234, 16'd4321, 8'd7);
    send_slot(slot(100, 100, 5, PAT_SINGLE));
    drain();
    load_regs(COLOR_RED, 9'd256, 16'd61, 16'd28, 8'd7);
    write_reg(CFG_SPARE, 16'hFFFF);
    end_cfg();
    send_slot(slot(7, 8, 7, PAT_BELOW));
    drain();
    load_regs(COLOR_BLUE, 9'd256, 16'hAAAA, 16'h5555, 8'd7);
    send_slot(slot(200, 150, 6, PAT_FROM));
    drain();

    // Random phases, each under a fresh register set.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_setup();
      for (int n = 0; n < SLOTS_PER_PHASE; n++) send_slot(rand_slot());
      drain();
    end

    // Let any stray pulse show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d pulses never came", sb.pending()));
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
